>>> rtl/core/nspa_pkg.sv
// Shared constants for the nearest slot pool allocator.
package nspa_pkg;

   localparam int DEFAULT_MAX_SLOTS  = 64;
   localparam int DEFAULT_ADDR_WIDTH = 64;

   localparam int SLOT_BYTES_W = 16;
   localparam int SLOT_COUNT_W = 7;
   localparam int FREE_COUNT_W = 7;
   localparam int SIZE_W       = 16;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 64;

   localparam logic [CSR_INDEX_W-1:0] CSR_POOL_BASE    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOT_BYTES   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOTS_IN_USE = 2'd2;

   localparam logic ACT_CLAIM   = 1'b0;
   localparam logic ACT_RELEASE = 1'b1;

   localparam logic [SLOT_BYTES_W-1:0] SLOT_BYTES_RESET   = 16'd1;
   localparam logic [SLOT_COUNT_W-1:0] SLOTS_IN_USE_RESET = 7'd64;

endpackage

>>> rtl/core/nearest_slot_pool_allocator.sv
// Top level of the nearest slot pool allocator: sequencer, scan datapath and bitmap.
//
// A transaction is taken at a clock edge with start high and busy low. The action
// selects a claim (grant the free slot nearest req_near_address, lowest index on a
// tie) or a release (free the slot based at req_slot_address).
// busy stays high while the sequencer walks the managed slots. A single
// adder steps the slot address by the stride each cycle, and a registered distance
// stage feeds one compare against the best candidate so far.
// The sequencer scans n managed slots, where n is the min of slots_in_use and MAX_SLOTS,
// then passes the drain and done states before the registered rsp_valid strobe.
// One transaction at a time; start is taken again in the cycle the result shows.
// The result is on rsp_* for exactly one cycle with rsp_valid high; the receiver
// cannot stall it.
// Configuration writes (csr_we, csr_index, csr_wdata) land at once; the user must
// make them only while busy is low, as the block does not enforce it.
// Reset clears the used bitmap (all slots free) and loads pool_base 1,
// slot_bytes 1 and slots_in_use 64.
module nearest_slot_pool_allocator
   import nspa_pkg::*;
#(
   parameter int MAX_SLOTS  = DEFAULT_MAX_SLOTS,
   parameter int ADDR_WIDTH = DEFAULT_ADDR_WIDTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic                    req_action,
   input  logic [SIZE_W-1:0]       req_request_size,
   input  logic [ADDR_WIDTH-1:0]   req_near_address,
   input  logic [ADDR_WIDTH-1:0]   req_slot_address,
   output logic                    rsp_valid,
   output logic [ADDR_WIDTH-1:0]   rsp_granted_address,
   output logic                    rsp_success,
   output logic [FREE_COUNT_W-1:0] rsp_free_slots,
   input  logic                    csr_we,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   localparam int IDX_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
   localparam int SPAN_W = SLOT_BYTES_W + IDX_W;
   localparam int ACC_W  = ((ADDR_WIDTH > SPAN_W) ? ADDR_WIDTH : SPAN_W) + 1;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0]              state_ff, state_in;
   logic [ADDR_WIDTH-1:0]   pool_base_ff;
   logic [SLOT_BYTES_W-1:0] slot_bytes_ff;
   logic [SLOT_COUNT_W-1:0] slots_in_use_ff;
   logic [MAX_SLOTS-1:0]    used_map_ff, used_map_in;

   logic                    op_ff, op_in;
   logic                    size_ok_ff, size_ok_in;
   logic                    rel_en_ff, rel_en_in;
   logic [ADDR_WIDTH-1:0]   near_ff, near_in;
   logic [ADDR_WIDTH-1:0]   slot_ff, slot_in;
   logic [CNT_W-1:0]        n_ff, n_in;
   logic [CNT_W-1:0]        idx_ff, idx_in;
   logic [ACC_W-1:0]        acc_ff, acc_in;
   logic [CNT_W-1:0]        free_cnt_ff, free_cnt_in;

   logic                    a_valid_ff, a_valid_in;
   logic [IDX_W-1:0]        a_idx_ff, a_idx_in;
   logic [ADDR_WIDTH-1:0]   a_dist_ff, a_dist_in;

   logic                    found_ff, found_in;
   logic [IDX_W-1:0]        best_idx_ff, best_idx_in;
   logic [ADDR_WIDTH-1:0]   best_dist_ff, best_dist_in;
   logic                    rel_hit_ff, rel_hit_in;
   logic [IDX_W-1:0]        rel_idx_ff, rel_idx_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [ADDR_WIDTH-1:0]   rsp_addr_ff, rsp_addr_in;
   logic                    rsp_success_ff, rsp_success_in;
   logic [FREE_COUNT_W-1:0] rsp_free_ff, rsp_free_in;

   logic                    accept;
   logic [IDX_W-1:0]        cur_idx;
   logic [ADDR_WIDTH-1:0]   cur_addr;
   logic                    cur_free;
   logic                    claim_ok;
   logic                    rel_was_used;
   logic [CNT_W-1:0]        free_final;

   assign accept   = start && (state_ff == ST_IDLE);
   assign cur_idx  = idx_ff[IDX_W-1:0];
   assign cur_addr = acc_ff[ADDR_WIDTH-1:0];
   assign cur_free = !used_map_ff[cur_idx];

   assign claim_ok     = (op_ff == ACT_CLAIM) && size_ok_ff && found_ff;
   assign rel_was_used = rel_hit_ff && used_map_ff[rel_idx_ff];
   assign free_final   = free_cnt_ff + CNT_W'(rel_was_used) - CNT_W'(claim_ok);

   always_comb begin
      state_in       = state_ff;
      used_map_in    = used_map_ff;
      op_in          = op_ff;
      size_ok_in     = size_ok_ff;
      rel_en_in      = rel_en_ff;
      near_in        = near_ff;
      slot_in        = slot_ff;
      n_in           = n_ff;
      idx_in         = idx_ff;
      acc_in         = acc_ff;
      free_cnt_in    = free_cnt_ff;
      a_valid_in     = 1'b0;
      a_idx_in       = a_idx_ff;
      a_dist_in      = a_dist_ff;
      found_in       = found_ff;
      best_idx_in    = best_idx_ff;
      best_dist_in   = best_dist_ff;
      rel_hit_in     = rel_hit_ff;
      rel_idx_in     = rel_idx_ff;
      rsp_valid_in   = 1'b0;
      rsp_addr_in    = rsp_addr_ff;
      rsp_success_in = rsp_success_ff;
      rsp_free_in    = rsp_free_ff;

      if (a_valid_ff && (!found_ff || (a_dist_ff < best_dist_ff))) begin
         found_in     = 1'b1;
         best_idx_in  = a_idx_ff;
         best_dist_in = a_dist_ff;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in       = req_action;
               size_ok_in  = (req_request_size != '0) && (req_request_size <= slot_bytes_ff);
               rel_en_in   = (req_action == ACT_RELEASE) && (slot_bytes_ff != '0);
               near_in     = req_near_address;
               slot_in     = req_slot_address;
               n_in        = (slots_in_use_ff > SLOT_COUNT_W'(MAX_SLOTS)) ?
                             CNT_W'(MAX_SLOTS) : slots_in_use_ff[CNT_W-1:0];
               idx_in      = '0;
               acc_in      = ACC_W'(pool_base_ff);
               free_cnt_in = '0;
               found_in    = 1'b0;
               rel_hit_in  = 1'b0;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (idx_ff == n_ff) begin
               state_in = ST_DRAIN;
            end else begin
               a_valid_in  = cur_free;
               a_idx_in    = cur_idx;
               a_dist_in   = (cur_addr > near_ff) ? (cur_addr - near_ff) : (near_ff - cur_addr);
               free_cnt_in = free_cnt_ff + CNT_W'(cur_free);
               if (rel_en_ff && (acc_ff == ACC_W'(slot_ff))) begin
                  rel_hit_in = 1'b1;
                  rel_idx_in = cur_idx;
               end
               acc_in = acc_ff + ACC_W'(slot_bytes_ff);
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (claim_ok) begin
               used_map_in[best_idx_ff] = 1'b1;
            end
            if (rel_hit_ff) begin
               used_map_in[rel_idx_ff] = 1'b0;
            end
            rsp_valid_in   = 1'b1;
            rsp_addr_in    = claim_ok ?
                             (pool_base_ff + ADDR_WIDTH'(SPAN_W'(best_idx_ff) *
                                                         SPAN_W'(slot_bytes_ff))) : '0;
            rsp_success_in = claim_ok || rel_hit_ff;
            rsp_free_in    = FREE_COUNT_W'(free_final);
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         used_map_ff     <= '0;
         a_valid_ff      <= 1'b0;
         found_ff        <= 1'b0;
         rel_hit_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         pool_base_ff    <= ADDR_WIDTH'(1);
         slot_bytes_ff   <= SLOT_BYTES_RESET;
         slots_in_use_ff <= SLOTS_IN_USE_RESET;
      end else begin
         state_ff     <= state_in;
         used_map_ff  <= used_map_in;
         a_valid_ff   <= a_valid_in;
         found_ff     <= found_in;
         rel_hit_ff   <= rel_hit_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_POOL_BASE:    pool_base_ff    <= csr_wdata[ADDR_WIDTH-1:0];
               CSR_SLOT_BYTES:   slot_bytes_ff   <= csr_wdata[SLOT_BYTES_W-1:0];
               CSR_SLOTS_IN_USE: slots_in_use_ff <= csr_wdata[SLOT_COUNT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      size_ok_ff     <= size_ok_in;
      rel_en_ff      <= rel_en_in;
      near_ff        <= near_in;
      slot_ff        <= slot_in;
      n_ff           <= n_in;
      idx_ff         <= idx_in;
      acc_ff         <= acc_in;
      free_cnt_ff    <= free_cnt_in;
      a_idx_ff       <= a_idx_in;
      a_dist_ff      <= a_dist_in;
      best_idx_ff    <= best_idx_in;
      best_dist_ff   <= best_dist_in;
      rel_idx_ff     <= rel_idx_in;
      rsp_addr_ff    <= rsp_addr_in;
      rsp_success_ff <= rsp_success_in;
      rsp_free_ff    <= rsp_free_in;
   end

   assign busy                = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_granted_address = rsp_addr_ff;
   assign rsp_success         = rsp_success_ff;
   assign rsp_free_slots      = rsp_free_ff;

endmodule

>>> rtl/core/nspa_checker.sv
// Port-level assertions for the nearest slot pool allocator, bound to the top level.
module nspa_checker
   import nspa_pkg::*;
#(
   parameter int MAX_SLOTS  = DEFAULT_MAX_SLOTS,
   parameter int ADDR_WIDTH = DEFAULT_ADDR_WIDTH
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    start,
   input logic                    busy,
   input logic                    rsp_valid,
   input logic [ADDR_WIDTH-1:0]   rsp_granted_address,
   input logic                    rsp_success,
   input logic [FREE_COUNT_W-1:0] rsp_free_slots
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   a_no_result_from_idle: assert property (@(posedge clock) disable iff (reset)
      !busy |=> !rsp_valid)
      else $error("result strobe without a transaction in flight");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_fail_zero_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_success) |-> (rsp_granted_address == '0))
      else $error("failed transaction returned a nonzero address");

   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_free_slots <= FREE_COUNT_W'(MAX_SLOTS)))
      else $error("free count above slot capacity");

endmodule

bind nearest_slot_pool_allocator nspa_checker #(
   .MAX_SLOTS  (MAX_SLOTS),
   .ADDR_WIDTH (ADDR_WIDTH)
) u_nspa_checker (.*);
